// ===== hw/rtl/ipr_pkg.sv =====
`default_nettype none

package ipr_pkg;

   localparam int ADDR_W      = 32;
   localparam int SLOT_W      = 4;
   localparam int OP_W        = 3;
   localparam int WIDE_IDX_W  = 9;   // holds any slot number up to 256
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_FIELD_W = 71;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 3'd0,
      OP_DELETE   = 3'd1,
      OP_LOOKUP   = 3'd2,
      OP_CONFLICT = 3'd3,
      OP_READ     = 3'd4,
      OP_CLEAR    = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_READ,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] read_end;
      logic [ADDR_W-1:0] read_begin;
      logic [SLOT_W-1:0] slot_out;
      logic              hit;
      status_type        status;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ipr_ram.sv =====
`default_nettype none

module ipr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ipr_cmp.sv =====
`default_nettype none

module ipr_cmp
   import ipr_pkg::*;
(
   input  wire logic              conflict,   // 0: point lookup, 1: range overlap
   input  wire logic [ADDR_W-1:0] range_low,
   input  wire logic [ADDR_W-1:0] range_high,
   input  wire logic [ADDR_W-1:0] ent_begin,
   input  wire logic [ADDR_W-1:0] ent_end,
   output logic                   match
);

   logic lo_ge_b, lo_le_e, hi_ge_b, hi_le_e;
   logic lo_in, hi_in, encloses;

   always_comb begin
      lo_ge_b  = range_low  >= ent_begin;
      lo_le_e  = range_low  <= ent_end;
      hi_ge_b  = range_high >= ent_begin;
      hi_le_e  = range_high <= ent_end;
      lo_in    = lo_ge_b && lo_le_e;
      hi_in    = hi_ge_b && hi_le_e;
      // new range strictly wraps the stored one
      encloses = !lo_ge_b && !hi_le_e;
      match    = conflict ? (lo_in || hi_in || encloses) : lo_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ip_range_table.sv =====
// Channel  Dir  Handshake            Payload
// req      in   req_tvalid/tready    tuser: opcode; tdata: range_low, range_high, slot_index
// rsp      out  rsp_tvalid/tready    tdata: status, hit, slot_out, read_begin, read_end
//
// An add walks the slots up to the first free one, or all of them when the table is full;
// lookup and conflict walk every slot.
// The lookup and conflict walk is set by the single range RAM read port feeding one
// shared comparator, one slot per cycle.
// Reset (synchronous) frees every slot at once; range contents are not cleared.
// The result sits in an output register; a stalled rsp side holds the sequencer in
// its final state, and the next request is taken once the sequencer is back in idle.
`default_nettype none

module ip_range_table
   import ipr_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [31:0] range_low, [63:32] range_high, [67:64] slot_index, [71:68] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] opcode
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [1:0] status, [2] hit, [6:3] slot_out, [38:7] read_begin, [70:39] read_end,
   // [71] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // sequencer and captured request
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [ADDR_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              idx_ok_ff, idx_ok_in;
   logic [SLOT_W-1:0] slot_echo_ff, slot_echo_in;

   // slot walk
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pipe_ff, pipe_in;       // RAM read in flight
   logic              pipe_vld_ff, pipe_vld_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;

   result_type        res_ff, res_in;
   result_type        rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // request unpack
   logic [ADDR_W-1:0]     req_lo, req_hi;
   logic [SLOT_W-1:0]     req_slot;
   logic [WIDE_IDX_W-1:0] req_wide;
   logic [IDX_W-1:0]      req_idx;
   logic                  req_ok;
   op_type                req_op;
   logic                  req_fire;

   logic [IDX_W-1:0]      scan_idx;
   logic [WIDE_IDX_W-1:0] scan_wide;
   logic                  scan_done;
   logic                  out_free;

   // RAM and compare unit
   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr, ram_raddr;
   logic [2*ADDR_W-1:0]   ram_wdata, ram_rdata;
   logic                  cmp_match;

   assign req_lo    = req_tdata[ADDR_W-1:0];
   assign req_hi    = req_tdata[2*ADDR_W-1:ADDR_W];
   assign req_slot  = req_tdata[2*ADDR_W+SLOT_W-1:2*ADDR_W];
   assign req_op    = op_type'(req_tuser);
   assign req_wide  = WIDE_IDX_W'(req_slot);
   assign req_idx   = req_wide[IDX_W-1:0];
   assign req_ok    = req_wide < WIDE_IDX_W'(ENTRIES);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;

   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_wide = WIDE_IDX_W'(scan_ff);
   assign scan_done = (scan_ff == CNT_W'(ENTRIES));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign ram_wdata = {hi_ff, lo_ff};

   ipr_ram #(
      .WIDTH (2 * ADDR_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ipr_cmp u_cmp (
      .conflict   (op_ff == OP_CONFLICT),
      .range_low  (lo_ff),
      .range_high (hi_ff),
      .ent_begin  (ram_rdata[ADDR_W-1:0]),
      .ent_end    (ram_rdata[2*ADDR_W-1:ADDR_W]),
      .match      (cmp_match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_op) inside
                  OP_ADD:                state_in = S_ADD;
                  OP_LOOKUP, OP_CONFLICT: state_in = S_SCAN;
                  OP_READ:               state_in = S_READ;
                  default:               state_in = S_EMIT;
               endcase
            end
         end
         S_ADD: begin
            if (scan_done || !valid_ff[scan_idx]) begin
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            if (scan_done && !pipe_ff) begin
               state_in = S_EMIT;
            end
         end
         S_READ: state_in = S_EMIT;
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      slot_echo_in = slot_echo_ff;
      scan_in      = scan_ff;
      pipe_in      = 1'b0;
      pipe_vld_in  = 1'b0;
      valid_in     = valid_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = scan_idx;
      ram_raddr    = scan_idx;

      unique case (state_ff)
         S_IDLE: begin
            ram_raddr = req_idx;
            if (req_fire) begin
               op_in        = req_op;
               lo_in        = req_lo;
               hi_in        = req_hi;
               idx_in       = req_idx;
               idx_ok_in    = req_ok;
               slot_echo_in = req_slot;
               scan_in      = '0;
               res_in       = '0;
               case (req_op)
                  OP_DELETE: begin
                     if (req_ok && valid_ff[req_idx]) begin
                        valid_in[req_idx] = 1'b0;
                     end else begin
                        res_in.status = STS_EMPTY;
                     end
                  end
                  OP_CLEAR: valid_in = '0;
                  default: ;
               endcase
            end
         end
         S_ADD: begin
            if (scan_done) begin
               res_in.status = STS_FULL;
            end else if (!valid_ff[scan_idx]) begin
               ram_we             = 1'b1;
               valid_in[scan_idx] = 1'b1;
               res_in.slot_out    = scan_wide[SLOT_W-1:0];
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (!scan_done) begin
               pipe_in     = 1'b1;
               pipe_vld_in = valid_ff[scan_idx];
               scan_in     = scan_ff + 1'b1;
            end
            if (pipe_ff && pipe_vld_ff && cmp_match) begin
               res_in.hit = 1'b1;
            end
         end
         S_READ: begin
            res_in.slot_out = slot_echo_ff;
            if (idx_ok_ff && valid_ff[idx_ff]) begin
               res_in.read_begin = ram_rdata[ADDR_W-1:0];
               res_in.read_end   = ram_rdata[2*ADDR_W-1:ADDR_W];
            end else begin
               res_in.status = STS_EMPTY;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pipe_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pipe_ff      <= pipe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      idx_ok_ff    <= idx_ok_in;
      slot_echo_ff <= slot_echo_in;
      scan_ff      <= scan_in;
      pipe_vld_ff  <= pipe_vld_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.read_end, rsp_ff.read_begin,
                        rsp_ff.slot_out, rsp_ff.hit, rsp_ff.status};

endmodule

`default_nettype wire

// ===== bench/tb_ip_range_table.sv =====
module tb_ip_range_table;
   timeunit 1ns;
   timeprecision 1ps;
   import ipr_pkg::*;

   localparam int TABLE_SLOTS     = 16;
   localparam int RANDOM_REQUESTS = 1430;
   localparam int MIX_SPAN        = 150;    // requests per traffic mix
   localparam int QUIET_SPAN_LO   = 600;    // random requests in this window run with no gaps
   localparam int QUIET_SPAN_HI   = 900;
   localparam int STALL_LIMIT     = 5000;   // cycles without any handshake before giving up
   localparam int GAP_PERCENT     = 26;

   // opcodes 6 and 7 are unused by the block and must answer all zeros
   localparam logic [OP_W-1:0]   OP_SPARE_6   = 3'd6;
   localparam logic [OP_W-1:0]   OP_SPARE_7   = 3'd7;
   // most random addresses land in one small window so ranges actually collide
   localparam logic [ADDR_W-1:0] CLUSTER_BASE = 32'h0A00_0000;

   typedef enum {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_type;

   // Shadow copy of the range table plus the queue of responses it predicts.
   class range_scoreboard;
      logic              range_valid [TABLE_SLOTS];
      logic [ADDR_W-1:0] range_begin [TABLE_SLOTS];
      logic [ADDR_W-1:0] range_end   [TABLE_SLOTS];
      result_type        table_answers[$];
      int                errors;
      int                op_count [8];
      int                full_refusals;
      int                hit_count;

      function new();
         foreach (range_valid[s]) begin
            range_valid[s] = 1'b0;
            range_begin[s] = '0;
            range_end[s]   = '0;
         end
         foreach (op_count[i]) op_count[i] = 0;
         errors        = 0;
         full_refusals = 0;
         hit_count     = 0;
      endfunction

      // Applies one accepted request to the shadow table and queues its response.
      function void apply_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] lo,
                                  logic [ADDR_W-1:0] hi, logic [SLOT_W-1:0] idx);
         result_type r;
         r = '0;
         op_count[op]++;
         case (op)
            OP_ADD: begin
               r.status = STS_FULL;
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (!range_valid[s]) begin
                     range_begin[s] = lo;
                     range_end[s]   = hi;
                     range_valid[s] = 1'b1;
                     r.status       = STS_OK;
                     r.slot_out     = SLOT_W'(s);
                     break;
                  end
               end
               if (r.status == STS_FULL) full_refusals++;
            end
            OP_DELETE: begin
               if (range_valid[idx]) range_valid[idx] = 1'b0;
               else r.status = STS_EMPTY;
            end
            OP_LOOKUP: begin
               for (int s = 0; s < TABLE_SLOTS; s++)
                  if (range_valid[s] && lo >= range_begin[s] && lo <= range_end[s])
                     r.hit = 1'b1;
            end
            OP_CONFLICT: begin
               // either end inside a stored range, or the new range strictly encloses it
               for (int s = 0; s < TABLE_SLOTS; s++)
                  if (range_valid[s] &&
                      ((lo >= range_begin[s] && lo <= range_end[s]) ||
                       (hi >= range_begin[s] && hi <= range_end[s]) ||
                       (lo < range_begin[s] && hi > range_end[s])))
                     r.hit = 1'b1;
            end
            OP_READ: begin
               r.slot_out = idx;
               if (range_valid[idx]) begin
                  r.read_begin = range_begin[idx];
                  r.read_end   = range_end[idx];
               end else begin
                  r.status = STS_EMPTY;
               end
            end
            OP_CLEAR: begin
               foreach (range_valid[s]) range_valid[s] = 1'b0;
            end
            default: ;
         endcase
         if (r.hit) hit_count++;
         table_answers.push_back(r);
      endfunction

      // Compares one accepted response against the oldest prediction.
      function void match_response(result_type got);
         result_type want;
         if (table_answers.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response with nothing outstanding: status %0d hit %0d slot %0d",
                        got.status, got.hit, got.slot_out);
            return;
         end
         want = table_answers.pop_front();
         if (got.status !== want.status || got.hit !== want.hit ||
             got.slot_out !== want.slot_out || got.read_begin !== want.read_begin ||
             got.read_end !== want.read_end) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: got  status %0d hit %0d slot %0d begin %h end %h",
                        got.status, got.hit, got.slot_out, got.read_begin, got.read_end);
               $display("       want status %0d hit %0d slot %0d begin %h end %h",
                        want.status, want.hit, want.slot_out, want.read_begin, want.read_end);
            end
         end
      endfunction
   endclass

   // All block inputs start at known values.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [31:0] range_low, [63:32] range_high,
                                             // [67:64] slot_index, [71:68] zero
   logic [OP_W-1:0]       req_tuser  = '0;   // [2:0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [1:0] status, [2] hit, [6:3] slot_out,
                                             // [38:7] read_begin, [70:39] read_end, [71] zero
   bit                    gaps_on    = 1'b1; // random gaps and stalls on both sides

   range_scoreboard sb;

   ip_range_table #(.ENTRIES(TABLE_SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Response side: stall at random, one update per falling edge.
   always @(negedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(99) >= GAP_PERCENT);
   end

   // Response monitor, sampled on the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_response(result_type'(rsp_tdata[RSP_FIELD_W-1:0]));
   end

   // Watchdog: ends the run if neither channel moves for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // Drives one request; returns on the falling edge after it was taken.
   // tvalid stays high straight into the next request unless a gap is drawn.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] lo,
                               input logic [ADDR_W-1:0] hi, input logic [SLOT_W-1:0] idx);
      while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, idx, hi, lo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.apply_request(op, lo, hi, idx);
      @(negedge clock);
   endtask

   // Sender holds off until every outstanding response is back.
   task automatic hold_until_answered();
      req_tvalid <= 1'b0;
      while (sb.table_answers.size() != 0) @(negedge clock);
   endtask

   // A slot that is in use if there is one, else a random slot.
   function automatic logic [SLOT_W-1:0] pick_slot();
      int unsigned start;
      start = $urandom_range(TABLE_SLOTS - 1);
      for (int k = 0; k < TABLE_SLOTS; k++)
         if (sb.range_valid[(start + k) % TABLE_SLOTS])
            return SLOT_W'((start + k) % TABLE_SLOTS);
      return SLOT_W'(start);
   endfunction

   // Address mix: fully random, near the ends of the space, in the busy window,
   // or right on / next to the bounds of a stored range.
   function automatic logic [ADDR_W-1:0] pick_addr();
      int unsigned       roll;
      logic [SLOT_W-1:0] s;
      roll = $urandom_range(99);
      if (roll < 10) return $urandom();
      if (roll < 16)
         return $urandom_range(1) ? ADDR_W'($urandom_range(3)) : ~ADDR_W'($urandom_range(3));
      s = pick_slot();
      if (roll < 50 || !sb.range_valid[s]) return CLUSTER_BASE + $urandom_range(2047);
      case ($urandom_range(5))
         0:       return sb.range_begin[s] - 1;
         1:       return sb.range_begin[s];
         2:       return sb.range_begin[s] + 1;
         3:       return sb.range_end[s] - 1;
         4:       return sb.range_end[s];
         default: return sb.range_end[s] + 1;
      endcase
   endfunction

   // End of a new range: mostly short, sometimes wild or reversed.
   function automatic logic [ADDR_W-1:0] pick_end(input logic [ADDR_W-1:0] lo);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return lo + $urandom_range(400);
      if (roll < 85) return $urandom();
      if (roll < 95) return lo - $urandom_range(1, 50);
      return '1;
   endfunction

   initial begin
      mix_type           mix;
      int unsigned       roll;
      int unsigned       add_w;
      int unsigned       del_w;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [SLOT_W-1:0] idx;

      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      send_request(OP_READ,   '1, '1, 4'd0);                 // read of a free slot
      send_request(OP_DELETE, '0, '0, 4'd15);                // delete of a free slot
      send_request(OP_ADD,    32'd0, 32'd0, 4'd0);           // slot 0: bottom of space
      send_request(OP_ADD,    '1, '1, 4'd15);                // slot 1: top of space
      send_request(OP_ADD,    32'd1000, 32'd2000, 4'd0);     // slot 2
      send_request(OP_ADD,    32'd3000, 32'd2500, 4'd0);     // slot 3: begin above end
      send_request(OP_LOOKUP, 32'd0, '1, 4'd0);              // hit at address zero
      send_request(OP_LOOKUP, '1, 32'd0, 4'd0);              // hit at all ones
      send_request(OP_LOOKUP, 32'd2000, 32'd0, 4'd0);        // hit on inclusive end
      send_request(OP_LOOKUP, 32'd2001, 32'd0, 4'd0);        // miss just past the end
      send_request(OP_CONFLICT, 32'd500, 32'd1000, 4'd0);    // new end inside
      send_request(OP_CONFLICT, 32'd2000, 32'd2400, 4'd0);   // new begin inside
      send_request(OP_CONFLICT, 32'd900, 32'd2100, 4'd0);    // new range encloses
      send_request(OP_CONFLICT, 32'd2100, 32'd2400, 4'd0);   // clear of everything
      send_request(OP_READ,   '0, '0, 4'd3);                 // reversed range reads back
      send_request(OP_ADD,    32'd1500, 32'd1600, 4'd0);     // overlapping add is stored
      send_request(OP_DELETE, '0, '0, 4'd2);
      send_request(OP_READ,   '0, '0, 4'd2);                 // now free
      send_request(OP_ADD,    32'd5, 32'd5, 4'd0);           // reuses slot 2
      send_request(OP_SPARE_6, '1, '1, 4'd15);               // unused opcodes answer zeros
      send_request(OP_SPARE_7, '1, '1, 4'd15);
      send_request(OP_CLEAR,  '0, '0, 4'd0);
      send_request(OP_LOOKUP, 32'd1500, 32'd0, 4'd0);        // miss after clear
      hold_until_answered();

      // ---- random part: fill, balanced and drain mixes in turn ----
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % MIX_SPAN == 0) begin
            hold_until_answered();
            case ((n / MIX_SPAN) % 3)
               0:       mix = MIX_FILL;
               1:       mix = MIX_BALANCED;
               default: mix = MIX_DRAIN;
            endcase
         end
         gaps_on = !(n >= QUIET_SPAN_LO && n < QUIET_SPAN_HI);

         case (mix)
            MIX_FILL:     begin add_w = 55; del_w = 5;  end
            MIX_BALANCED: begin add_w = 30; del_w = 15; end
            default:      begin add_w = 12; del_w = 35; end
         endcase
         roll = $urandom_range(99);
         if (roll < add_w)                  op = OP_ADD;
         else if (roll < add_w + del_w)     op = OP_DELETE;
         else if (roll < add_w + del_w + 15) op = OP_LOOKUP;
         else if (roll < add_w + del_w + 30) op = OP_CONFLICT;
         else if (roll < 96)                op = OP_READ;
         else if (roll < 97)                op = OP_CLEAR;
         else if (roll < 98)                op = OP_SPARE_6;
         else                               op = OP_SPARE_7;

         // fields an opcode ignores still carry random bits
         lo  = $urandom();
         hi  = $urandom();
         idx = SLOT_W'($urandom_range(TABLE_SLOTS - 1));
         case (op)
            OP_ADD, OP_CONFLICT: begin
               lo = pick_addr();
               hi = pick_end(lo);
            end
            OP_LOOKUP: lo = pick_addr();
            OP_DELETE, OP_READ: if ($urandom_range(3) != 0) idx = pick_slot();
            default: ;
         endcase
         send_request(op, lo, hi, idx);
      end

      hold_until_answered();
      repeat (TABLE_SLOTS + 8) @(posedge clock);

      $display("Covered %0d adds (%0d refused on a full table), %0d deletes, %0d lookups,",
               sb.op_count[OP_ADD], sb.full_refusals, sb.op_count[OP_DELETE],
               sb.op_count[OP_LOOKUP]);
      $display("%0d conflict checks, %0d reads, %0d clears, %0d unused opcodes; %0d hits",
               sb.op_count[OP_CONFLICT], sb.op_count[OP_READ], sb.op_count[OP_CLEAR],
               sb.op_count[OP_SPARE_6] + sb.op_count[OP_SPARE_7], sb.hit_count);
      if (sb.errors == 0 && sb.table_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.errors, sb.table_answers.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
